// ===== rtl/core/eu8_pkg.sv =====
// shared types and constants of the 8-bit execute unit
package eu8_pkg;

	localparam int REG_COUNT  = 64;
	localparam int DATA_DEPTH = 2048;
	// the address field is six bits wide, so only the low part of the data store is reachable
	localparam int DATA_WORDS = (DATA_DEPTH < 64) ? DATA_DEPTH : 64;
	localparam int RA_W       = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int DA_W       = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_MOVI = 4'd3,
		OP_BEQZ = 4'd4,
		OP_ANDI = 4'd5,
		OP_EOR  = 4'd6,
		OP_BR   = 4'd7,
		OP_SAL  = 4'd8,
		OP_SAR  = 4'd9,
		OP_LDR  = 4'd10,
		OP_STR  = 4'd11
	} op_t;

	// flag positions inside the status word
	localparam int FLAG_C = 4;
	localparam int FLAG_V = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_S = 1;
	localparam int FLAG_Z = 0;

	typedef struct packed {
		logic [15:0] next_address;
		logic        taken;
		logic        wr;
		logic        st;
		logic [7:0]  value;
		logic [4:0]  flags;
		logic        bad;
	} alu_res_t;

endpackage

// ===== rtl/core/eu8_if.sv =====
// handshake channels for instructions and results
interface eu8_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [5:0]  reg_first;
	logic [5:0]  reg_second_or_imm;
	logic [15:0] instr_address;

	modport source (output valid, op, reg_first, reg_second_or_imm, instr_address,
		input ready);
	modport sink (input valid, op, reg_first, reg_second_or_imm, instr_address,
		output ready);
endinterface

interface eu8_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       next_address;
	logic              branch_taken;
	logic              reg_written;
	logic signed [7:0] written_value;
	logic [4:0]        flags;
	logic              bad_opcode;

	modport source (output valid, next_address, branch_taken, reg_written, written_value,
		flags, bad_opcode, input ready);
	modport sink (input valid, next_address, branch_taken, reg_written, written_value,
		flags, bad_opcode, output ready);
endinterface

// ===== rtl/core/eu8_ram.sv =====
// generic single-write RAM with registered read
module eu8_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/eu8_alu.sv =====
// instruction datapath: result, flags and next address of one instruction
module eu8_alu import eu8_pkg::*; (
	input  logic [3:0]  op,
	input  logic [5:0]  rb,
	input  logic [15:0] pc,
	input  logic [7:0]  a,
	input  logic [7:0]  b,
	input  logic [7:0]  mem_data,
	input  logic [4:0]  flags_in,
	output alu_res_t    res
);

	logic [7:0]  imm_s;
	logic [8:0]  sum;
	logic [7:0]  diff;
	logic [15:0] prod;
	logic [7:0]  r;
	logic [15:0] pc_inc;
	logic [4:0]  f;

	assign imm_s  = {{2{rb[5]}}, rb};
	assign sum    = {1'b0, a} + {1'b0, b};
	assign diff   = a - b;
	assign prod   = a * b;
	assign pc_inc = pc + 16'd1;

	always_comb begin
		r                = 8'd0;
		f                = flags_in;
		res.next_address = pc_inc;
		res.taken        = 1'b0;
		res.wr           = 1'b0;
		res.st           = 1'b0;
		res.bad          = 1'b0;
		case (op_t'(op))
			OP_ADD: begin
				r         = sum[7:0];
				f[FLAG_C] = sum[8];
				f[FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
				res.wr    = 1'b1;
			end
			OP_SUB: begin
				r         = diff;
				f[FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
				res.wr    = 1'b1;
			end
			OP_MUL: begin
				r      = prod[7:0];
				res.wr = 1'b1;
			end
			OP_MOVI: begin
				r      = imm_s;
				res.wr = 1'b1;
			end
			OP_BEQZ: begin
				if (a == 8'd0) begin
					res.next_address = pc_inc + {10'd0, rb};
					res.taken        = 1'b1;
				end
			end
			OP_ANDI: begin
				r      = a & imm_s;
				res.wr = 1'b1;
			end
			OP_EOR: begin
				r      = a ^ b;
				res.wr = 1'b1;
			end
			OP_BR: begin
				res.next_address = {a, b};
				res.taken        = 1'b1;
			end
			OP_SAL: begin
				r      = (rb[5:3] != 3'd0) ? 8'd0 : (a << rb[2:0]);
				res.wr = 1'b1;
			end
			OP_SAR: begin
				r      = (rb[5:3] != 3'd0) ? {8{a[7]}} : 8'($signed(a) >>> rb[2:0]);
				res.wr = 1'b1;
			end
			OP_LDR: begin
				r      = mem_data;
				res.wr = 1'b1;
			end
			OP_STR: begin
				res.st = 1'b1;
			end
			default: begin
				res.bad = 1'b1;
			end
		endcase

		// n and z follow every arithmetic and logic op, s follows n and v on add and subtract
		case (op_t'(op))
			OP_ADD, OP_SUB, OP_MUL, OP_ANDI, OP_EOR, OP_SAL, OP_SAR: begin
				f[FLAG_N] = r[7];
				f[FLAG_Z] = (r == 8'd0);
			end
			default: begin
			end
		endcase
		case (op_t'(op))
			OP_ADD, OP_SUB: begin
				f[FLAG_S] = f[FLAG_N] ^ f[FLAG_V];
			end
			default: begin
			end
		endcase

		res.flags = f;
		res.value = (op_t'(op) == OP_STR) ? a : r;
	end

endmodule

// ===== rtl/core/eight_bit_cpu_execute_unit_top.sv =====
// Execute unit of an 8-bit load/store core. It takes one decoded instruction per clock and
// keeps a steady rate of one item per cycle while the output does not stall; an accepted item
// passes through the register file and data store reads, which sit in RAMs with a registered
// read port, then through the output register. The value written by an instruction is
// forwarded to the one right behind it, so dependent instructions run back to back.
// Both stores read as zero after reset through per-entry valid bits, so there is no
// clearing pass and the block is ready at once. The data store holds 64 bytes, as far as
// the six-bit immediate address reaches. The input stalls only while a finished result
// waits in the output register and the sink is not ready.
module eight_bit_cpu_execute_unit_top import eu8_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	eu8_in_if.sink        instr,
	eu8_out_if.source     result
);

	logic        accept;
	logic        advance;
	logic        leave;

	logic        v_s1;
	logic [3:0]  op_s1;
	logic [5:0]  ra_s1;
	logic [5:0]  rb_s1;
	logic [15:0] pc_s1;
	logic        av_s1;
	logic        bv_s1;
	logic        dv_s1;

	logic [REG_COUNT-1:0]  rvalid_q;
	logic [DATA_WORDS-1:0] dvalid_q;

	logic        rfwd_v_q;
	logic [5:0]  rfwd_addr_q;
	logic [7:0]  rfwd_data_q;
	logic        dfwd_v_q;
	logic [5:0]  dfwd_addr_q;
	logic [7:0]  dfwd_data_q;

	logic [4:0]  flags_q;

	logic [7:0]  a_ram;
	logic [7:0]  b_ram;
	logic [7:0]  d_ram;
	logic [7:0]  a_val;
	logic [7:0]  b_val;
	logic [7:0]  d_val;
	logic        ra_ok;
	logic        rb_ok;
	logic        d_ok;
	logic        rf_we;
	logic        ds_we;
	alu_res_t    alu_res;

	logic              out_v_q;
	logic [15:0]       next_address_q;
	logic              branch_taken_q;
	logic              reg_written_q;
	logic signed [7:0] written_value_q;
	logic [4:0]        flags_out_q;
	logic              bad_opcode_q;

	assign advance     = !out_v_q || result.ready;
	assign leave       = v_s1 && advance;
	assign instr.ready = !v_s1 || advance;
	assign accept      = instr.valid && instr.ready;

	assign ra_ok = {1'b0, ra_s1} < 7'(REG_COUNT);
	assign rb_ok = {1'b0, rb_s1} < 7'(REG_COUNT);
	assign d_ok  = {1'b0, rb_s1} < 7'(DATA_WORDS);

	eu8_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (ra_s1[RA_W-1:0]),
		.wdata (alu_res.value),
		.re    (accept),
		.raddr (instr.reg_first[RA_W-1:0]),
		.rdata (a_ram)
	);

	eu8_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (ra_s1[RA_W-1:0]),
		.wdata (alu_res.value),
		.re    (accept),
		.raddr (instr.reg_second_or_imm[RA_W-1:0]),
		.rdata (b_ram)
	);

	eu8_ram #(.WIDTH(8), .DEPTH(DATA_WORDS)) u_data (
		.clk   (clk),
		.we    (ds_we),
		.waddr (rb_s1[DA_W-1:0]),
		.wdata (alu_res.value),
		.re    (accept),
		.raddr (instr.reg_second_or_imm[DA_W-1:0]),
		.rdata (d_ram)
	);

	// the previous instruction writes on the same edge as this one reads, so take its value
	always_comb begin
		if (!ra_ok) begin
			a_val = 8'd0;
		end else if (rfwd_v_q && rfwd_addr_q == ra_s1) begin
			a_val = rfwd_data_q;
		end else begin
			a_val = av_s1 ? a_ram : 8'd0;
		end
		if (!rb_ok) begin
			b_val = 8'd0;
		end else if (rfwd_v_q && rfwd_addr_q == rb_s1) begin
			b_val = rfwd_data_q;
		end else begin
			b_val = bv_s1 ? b_ram : 8'd0;
		end
		if (!d_ok) begin
			d_val = 8'd0;
		end else if (dfwd_v_q && dfwd_addr_q == rb_s1) begin
			d_val = dfwd_data_q;
		end else begin
			d_val = dv_s1 ? d_ram : 8'd0;
		end
	end

	eu8_alu u_alu (
		.op       (op_s1),
		.rb       (rb_s1),
		.pc       (pc_s1),
		.a        (a_val),
		.b        (b_val),
		.mem_data (d_val),
		.flags_in (flags_q),
		.res      (alu_res)
	);

	assign rf_we = leave && alu_res.wr && ra_ok;
	assign ds_we = leave && alu_res.st && d_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rvalid_q    <= '0;
			dvalid_q    <= '0;
			rfwd_v_q    <= 1'b0;
			dfwd_v_q    <= 1'b0;
			flags_q     <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (leave) begin
				v_s1 <= 1'b0;
			end
			if (rf_we) begin
				rvalid_q[ra_s1[RA_W-1:0]] <= 1'b1;
				rfwd_v_q                  <= 1'b1;
			end
			if (ds_we) begin
				dvalid_q[rb_s1[DA_W-1:0]] <= 1'b1;
				dfwd_v_q                  <= 1'b1;
			end
			if (leave) begin
				flags_q <= alu_res.flags;
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= instr.op;
			ra_s1 <= instr.reg_first;
			rb_s1 <= instr.reg_second_or_imm;
			pc_s1 <= instr.instr_address;
			av_s1 <= rvalid_q[instr.reg_first[RA_W-1:0]];
			bv_s1 <= rvalid_q[instr.reg_second_or_imm[RA_W-1:0]];
			dv_s1 <= dvalid_q[instr.reg_second_or_imm[DA_W-1:0]];
		end
		if (rf_we) begin
			rfwd_addr_q <= ra_s1;
			rfwd_data_q <= alu_res.value;
		end
		if (ds_we) begin
			dfwd_addr_q <= rb_s1;
			dfwd_data_q <= alu_res.value;
		end
		if (leave) begin
			next_address_q  <= alu_res.next_address;
			branch_taken_q  <= alu_res.taken;
			reg_written_q   <= alu_res.wr && ra_ok;
			written_value_q <= (alu_res.wr || alu_res.st) ? alu_res.value : 8'sd0;
			flags_out_q     <= alu_res.flags;
			bad_opcode_q    <= alu_res.bad;
		end
	end

	assign result.valid         = out_v_q;
	assign result.next_address  = next_address_q;
	assign result.branch_taken  = branch_taken_q;
	assign result.reg_written   = reg_written_q;
	assign result.written_value = written_value_q;
	assign result.flags         = flags_out_q;
	assign result.bad_opcode    = bad_opcode_q;

	// a stalled item stays in the read stage
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !advance |=> v_s1)
		else $error("read stage item lost while output stalled");

	// no store is touched without an item in the read stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(rf_we || ds_we) |-> leave)
		else $error("store written without a leaving item");

	// an invalid opcode leaves the flags alone
	assert property (@(posedge clk) disable iff (!arst_n)
		leave && alu_res.bad |=> flags_q == $past(flags_q))
		else $error("flags changed by invalid opcode");

	// the reported flags match the status register once the result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		leave |=> out_v_q && flags_out_q == flags_q)
		else $error("reported flags differ from status register");

endmodule
